// ----- src/fss_pkg.sv -----
// Shared types, constants and character decode for the format specifier scanner.
`timescale 1ns / 1ps
package fss_pkg;

    localparam int MAX_MESSAGE_LENGTH = 4096;
    localparam int POS_W              = $clog2(MAX_MESSAGE_LENGTH + 1);
    localparam int START_W            = $clog2(MAX_MESSAGE_LENGTH);
    localparam int CHAR_W             = 16;
    localparam int START_FIELD_W      = 12;
    localparam int END_FIELD_W        = 13;

    localparam logic [CHAR_W-1:0] CH_PCT   = 16'h0025;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 16'h002B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
    localparam logic [CHAR_W-1:0] CH_0     = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_9     = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 16'h005A;
    localparam logic [CHAR_W-1:0] CH_CASE  = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_D     = 16'h0064;
    localparam logic [CHAR_W-1:0] CH_F     = 16'h0066;
    localparam logic [CHAR_W-1:0] CH_S     = 16'h0073;
    localparam logic [CHAR_W-1:0] CH_C     = 16'h0063;
    localparam logic [CHAR_W-1:0] CH_P     = 16'h0070;
    localparam logic [CHAR_W-1:0] CH_V     = 16'h0076;
    localparam logic [CHAR_W-1:0] CH_L     = 16'h006C;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN,
        PH_SIGN,
        PH_WIDTH,
        PH_PREC
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PCT,
        KIND_D,
        KIND_F,
        KIND_S,
        KIND_C,
        KIND_P,
        KIND_V,
        KIND_L
    } t_kind;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_kind_dec;

    typedef struct packed {
        t_phase next_phase;
        logic   found;
        t_kind  kind;
        logic   needs;
    } t_step;

    function automatic t_kind_dec kind_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] lc;
        t_kind_dec         r;
        lc     = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CH_CASE : c;
        r.hit  = 1'b1;
        r.kind = KIND_PCT;
        case (lc)
            CH_PCT:  r.kind = KIND_PCT;
            CH_D:    r.kind = KIND_D;
            CH_F:    r.kind = KIND_F;
            CH_S:    r.kind = KIND_S;
            CH_C:    r.kind = KIND_C;
            CH_P:    r.kind = KIND_P;
            CH_V:    r.kind = KIND_V;
            CH_L:    r.kind = KIND_L;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/fss_char_if.sv -----
// Channel interface carrying one message character per beat.
`timescale 1ns / 1ps
interface fss_char_if;
    import fss_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_in_message;

    modport source (output valid, output char_code, output last_in_message, input ready);
    modport sink   (input valid, input char_code, input last_in_message, output ready);
endinterface

// ----- src/fss_res_if.sv -----
// Channel interface carrying one scan result per beat.
`timescale 1ns / 1ps
interface fss_res_if;
    import fss_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     format_found;
    logic [2:0]               format_kind;
    logic [START_FIELD_W-1:0] start_position;
    logic [END_FIELD_W-1:0]   end_position;
    logic                     needs_formatter;
    logic                     message_end;

    modport source (output valid, output format_found, output format_kind,
                    output start_position, output end_position,
                    output needs_formatter, output message_end, input ready);
    modport sink   (input valid, input format_found, input format_kind,
                    input start_position, input end_position,
                    input needs_formatter, input message_end, output ready);
endinterface

// ----- src/fss_step.sv -----
// Per-character specifier state machine: next phase and completion decode.
`timescale 1ns / 1ps
module fss_step
    import fss_pkg::*;
(
    input  t_phase            i_phase,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_keep,
    output t_step             o_step
);
    t_kind_dec w_kd;
    logic      w_digit;
    t_phase    n_phase;

    assign w_kd    = kind_of(i_char_code);
    assign w_digit = (i_char_code >= CH_0) && (i_char_code <= CH_9);

    // next phase
    always_comb begin
        n_phase = PH_IDLE;
        case (i_phase)
            PH_IDLE: begin
                n_phase = (i_char_code == CH_PCT) ? PH_OPEN : PH_IDLE;
            end
            PH_OPEN: begin
                if (w_kd.hit) begin
                    n_phase = PH_IDLE;
                end else if (i_char_code == CH_PLUS || i_char_code == CH_MINUS) begin
                    n_phase = PH_SIGN;
                end else if (w_digit) begin
                    n_phase = PH_WIDTH;
                end
            end
            PH_SIGN: begin
                n_phase = (!w_kd.hit && w_digit) ? PH_WIDTH : PH_IDLE;
            end
            PH_WIDTH: begin
                if (w_kd.hit) begin
                    n_phase = PH_IDLE;
                end else if (i_char_code == CH_DOT) begin
                    n_phase = PH_PREC;
                end else if (w_digit) begin
                    n_phase = PH_WIDTH;
                end
            end
            PH_PREC: begin
                n_phase = (!w_kd.hit && w_digit) ? PH_PREC : PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // completion outputs
    always_comb begin
        o_step.next_phase = n_phase;
        o_step.kind       = w_kd.kind;
        o_step.found      = (i_phase != PH_IDLE) && w_kd.hit &&
                            (i_keep || (w_kd.kind != KIND_PCT && w_kd.kind != KIND_P));
        o_step.needs      = (i_phase != PH_OPEN) || (w_kd.kind == KIND_D) ||
                            (w_kd.kind == KIND_F);
    end
endmodule

// ----- src/format_specifier_scanner_unit.sv -----
// Top level of the percent-format specifier scanner.
// Usage:
//   i_char carries one message character per beat with last_in_message
//   marking the final character. o_res carries a beat when a kept specifier
//   completes (format_found with kind, start, exclusive end, needs_formatter)
//   or when the character closed its message (message_end); other
//   characters give no beat. Unfound fields read zero.
//   i_cfg_wr_en / i_cfg_wr_data write keep_parameterless; write it only
//   while the block is idle.
// Flow:
//   One character per cycle sustained while o_res takes its beats. A character
//   is taken into the input register when accepted; one pass of decode and
//   state update then loads the result register, which offers the result beat.
// Reset (synchronous, active low): scan idle, position zero,
//   keep_parameterless set, both register stages empty.
// Stall: when o_res is held off the result register keeps its beat, the
//   input register still fills once, then i_char.ready drops.
`timescale 1ns / 1ps
module format_specifier_scanner_unit
    import fss_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_wr_en,
    input  logic   i_cfg_wr_data,
    fss_char_if.sink   i_char,
    fss_res_if.source  o_res
);
    logic              r_keep;
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    t_phase            r_phase;
    logic [POS_W-1:0]  r_pos;
    logic [START_W-1:0] r_start;
    logic              r_out_valid;
    logic              r_found;
    t_kind             r_kind;
    logic [START_FIELD_W-1:0] r_spos;
    logic [END_FIELD_W-1:0]   r_epos;
    logic              r_needs;
    logic              r_mend;

    t_step             w_step;
    logic              w_adv;
    logic              w_emit;
    logic [POS_W-1:0]  n_pos;
    logic [START_W-1:0] n_start;
    t_phase            n_phase;
    logic [POS_W-1:0]  w_epos;

    fss_step u_step (
        .i_phase     (r_phase),
        .i_char_code (r_char),
        .i_keep      (r_keep),
        .o_step      (w_step)
    );

    assign w_adv        = !r_out_valid || o_res.ready;
    assign i_char.ready = !r_in_valid || w_adv;
    assign w_emit       = r_in_valid && (w_step.found || r_last);

    assign w_epos = (r_pos == POS_W'(MAX_MESSAGE_LENGTH)) ? r_pos : r_pos + 1'b1;

    always_comb begin
        n_phase = r_last ? PH_IDLE : w_step.next_phase;
        n_pos   = (r_pos < POS_W'(MAX_MESSAGE_LENGTH)) ? r_pos + 1'b1 : r_pos;
        n_start = r_start;
        if (r_phase == PH_IDLE && r_char == CH_PCT) begin
            n_start = (r_pos < POS_W'(MAX_MESSAGE_LENGTH)) ? r_pos[START_W-1:0]
                                                          : START_W'(MAX_MESSAGE_LENGTH - 1);
        end
        if (r_last) begin
            n_pos   = '0;
            n_start = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep      <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_start     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_keep <= i_cfg_wr_data;
            end
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (w_adv) begin
                r_out_valid <= w_emit;
                if (r_in_valid) begin
                    r_phase <= n_phase;
                    r_pos   <= n_pos;
                    r_start <= n_start;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.char_code;
            r_last <= i_char.last_in_message;
        end
        if (w_adv && w_emit) begin
            r_found <= w_step.found;
            r_kind  <= w_step.found ? w_step.kind : KIND_PCT;
            r_spos  <= w_step.found ? START_FIELD_W'(r_start) : '0;
            r_epos  <= w_step.found ? END_FIELD_W'(w_epos) : '0;
            r_needs <= w_step.found && w_step.needs;
            r_mend  <= r_last;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.format_found    = r_found;
    assign o_res.format_kind     = r_kind;
    assign o_res.start_position  = r_spos;
    assign o_res.end_position    = r_epos;
    assign o_res.needs_formatter = r_needs;
    assign o_res.message_end     = r_mend;
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the format specifier scanner: random and directed messages.
`timescale 1ns / 1ps
module testbench;
    import fss_pkg::*;

    localparam int    DRAIN_LIMIT  = 5000;
    localparam int    SETTLE_TICKS = 8;
    localparam string TYPE_LETTERS = "%dfscpvl";

    typedef struct packed {
        logic                     found;
        t_kind                    kind;
        logic [START_FIELD_W-1:0] start_pos;
        logic [END_FIELD_W-1:0]   end_pos;
        logic                     needs;
        logic                     msg_end;
    } t_scan_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    fss_char_if char_ch ();
    fss_res_if  res_ch ();

    format_specifier_scanner_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_char        (char_ch),
        .o_res         (res_ch)
    );

    // scanner shadow state
    t_phase       scan_phase = PH_IDLE;
    int           char_pos = 0;
    int           spec_start = 0;
    logic         keep_escape_proc = 1'b1;
    t_scan_result pending_scans[$];

    int   mismatches = 0;
    int   chars_sent = 0;
    int   hold_cycles = 0;
    logic idle_on = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

    function automatic void predict_scan(input logic [CHAR_W-1:0] c, input logic last);
        t_scan_result r;
        logic [CHAR_W-1:0] lc;
        logic is_type;
        logic is_digit;
        logic flagged;
        t_kind k;
        int idx;
        int stop;
        r = '0;
        idx = char_pos;
        is_digit = (c >= CH_0 && c <= CH_9);
        lc = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CH_CASE) : c;
        is_type = 1'b0;
        k = KIND_PCT;
        for (int i = 0; i < 8; i++) begin
            if (lc == {8'h00, TYPE_LETTERS[i]}) begin
                is_type = 1'b1;
                k = t_kind'(i);
            end
        end
        if (scan_phase == PH_IDLE) begin
            if (c == CH_PCT) begin
                scan_phase = PH_OPEN;
                spec_start = (idx < MAX_MESSAGE_LENGTH) ? idx : MAX_MESSAGE_LENGTH - 1;
            end
        end else if (is_type) begin
            flagged = (scan_phase != PH_OPEN);
            scan_phase = PH_IDLE;
            if (keep_escape_proc || (k != KIND_PCT && k != KIND_P)) begin
                stop = (idx + 1 > MAX_MESSAGE_LENGTH) ? MAX_MESSAGE_LENGTH : idx + 1;
                r.found = 1'b1;
                r.kind = k;
                r.start_pos = spec_start[START_FIELD_W-1:0];
                r.end_pos = stop[END_FIELD_W-1:0];
                r.needs = flagged || k == KIND_D || k == KIND_F;
            end
        end else begin
            case (scan_phase)
                PH_OPEN: begin
                    if (c == CH_PLUS || c == CH_MINUS) scan_phase = PH_SIGN;
                    else if (is_digit) scan_phase = PH_WIDTH;
                    else scan_phase = PH_IDLE;
                end
                PH_SIGN: scan_phase = is_digit ? PH_WIDTH : PH_IDLE;
                PH_WIDTH: begin
                    if (c == CH_DOT) scan_phase = PH_PREC;
                    else if (!is_digit) scan_phase = PH_IDLE;
                end
                default: begin
                    if (!is_digit) scan_phase = PH_IDLE;
                end
            endcase
        end
        if (char_pos < MAX_MESSAGE_LENGTH) char_pos++;
        if (last) begin
            scan_phase = PH_IDLE;
            char_pos = 0;
            spec_start = 0;
        end
        r.msg_end = last;
        if (r.found || last) pending_scans = {pending_scans, r};
    endfunction

    function automatic void note_error(input string what, input t_scan_result want,
                                       input t_scan_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%t %s: exp found=%0b kind=%0d start=%0d end=%0d needs=%0b last=%0b",
                     $realtime, what, want.found, want.kind, want.start_pos, want.end_pos,
                     want.needs, want.msg_end);
            $display("    got found=%0b kind=%0d start=%0d end=%0d needs=%0b last=%0b",
                     got.found, got.kind, got.start_pos, got.end_pos, got.needs, got.msg_end);
        end
    endfunction

    function automatic void check_scan_result();
        t_scan_result got;
        t_scan_result want;
        got.found = res_ch.format_found;
        got.kind = t_kind'(res_ch.format_kind);
        got.start_pos = res_ch.start_position;
        got.end_pos = res_ch.end_position;
        got.needs = res_ch.needs_formatter;
        got.msg_end = res_ch.message_end;
        if (pending_scans.size() == 0) begin
            note_error("unexpected beat", '0, got);
            return;
        end
        want = pending_scans.pop_front();
        if (got.found !== want.found || got.kind !== want.kind
                || got.start_pos !== want.start_pos || got.end_pos !== want.end_pos
                || got.needs !== want.needs || got.msg_end !== want.msg_end) begin
            note_error("mismatch", want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready) check_scan_result();
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result-side ready: random stalls, plus a long hold-off on request
    initial begin
        int span;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                span = hold_cycles;
                hold_cycles = 0;
                res_ch.ready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
                res_ch.ready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.char_code <= c;
        char_ch.last_in_message <= last;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        predict_scan(c, last);
        chars_sent++;
    endtask

    task automatic send_string(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++) begin
            send_char({8'h00, s[i]}, last_at_end && i == s.len() - 1);
        end
    endtask

    task automatic wait_idle();
        int guard;
        char_ch.valid <= 1'b0;
        guard = 0;
        while (pending_scans.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_keep(input logic v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        keep_escape_proc = v;
    endtask

    function automatic logic [CHAR_W-1:0] plain_char();
        return CH_0 + CHAR_W'($urandom_range(0, 16'h7E - 16'h30));
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char();
        return CH_0 + CHAR_W'($urandom_range(0, 9));
    endfunction

    function automatic logic rand_last();
        return $urandom_range(0, 29) == 0;
    endfunction

    task automatic send_good_spec();
        int width_digits;
        logic [7:0] t;
        send_char(CH_PCT, rand_last());
        if ($urandom_range(0, 2) == 0) send_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS,
                                                 rand_last());
        width_digits = $urandom_range(0, 3);
        repeat (width_digits) send_char(digit_char(), rand_last());
        if (width_digits > 0 && $urandom_range(0, 2) == 0) begin
            send_char(CH_DOT, rand_last());
            repeat ($urandom_range(0, 2)) send_char(digit_char(), rand_last());
        end
        t = TYPE_LETTERS[$urandom_range(0, 7)];
        if (t != "%" && $urandom_range(0, 1)) t = t - 8'h20;
        send_char({8'h00, t}, rand_last());
    endtask

    task automatic send_broken_spec();
        string junk;
        junk = "+-.0123456789xyz%#";
        send_char(CH_PCT, rand_last());
        repeat ($urandom_range(1, 3)) begin
            send_char({8'h00, junk[$urandom_range(0, junk.len() - 1)]}, rand_last());
        end
    endtask

    task automatic test_all_kinds();
        idle_on = 1'b0;
        send_string("%%%d%F%s%C%p%V%l", 1'b1);
    endtask

    task automatic test_flags_and_aborts();
        send_char(16'h0000, 1'b0);
        send_char(16'hFFFF, 1'b0);
        send_string("%+9.1d%-x%3.w%1", 1'b1);
    endtask

    task automatic test_dropped_kinds();
        wait_idle();
        write_keep(1'b0);
        send_string("%%%p%P%d", 1'b1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_keep(1'b1);
        idle_on = 1'b0;
        hold_cycles = 200;
        repeat (30) send_string("%d", 1'b0);
        wait_idle();
        repeat (10) send_string("%+s", 1'b0);
        send_string("%v", 1'b1);
    endtask

    // saturation of the position counter near and past the length limit
    task automatic test_long_message();
        int n;
        wait_idle();
        idle_on = 1'b0;
        n = 0;
        while (n < 4088) begin
            if ($urandom_range(0, 47) == 0) begin
                send_string("%d", 1'b0);
                n += 2;
            end else begin
                send_char(plain_char(), 1'b0);
                n++;
            end
        end
        while (n < MAX_MESSAGE_LENGTH - 1) begin
            send_char(plain_char(), 1'b0);
            n++;
        end
        send_string("%+3s", 1'b0);
        send_string("ab%-12.3f", 1'b0);
        send_string("%c%v", 1'b1);
    endtask

    task automatic test_random(input int n_items, input logic keep, input logic idling);
        int first;
        int pick;
        wait_idle();
        write_keep(keep);
        idle_on = idling;
        first = chars_sent;
        while (chars_sent - first < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) send_good_spec();
            else if (pick == 7) send_char(plain_char(), rand_last());
            else if (pick == 8) send_char(CHAR_W'($urandom_range(1, 65535)), rand_last());
            else send_broken_spec();
            if ($urandom_range(0, 149) == 0) wait_idle();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        char_ch.valid <= 1'b0;
        char_ch.char_code <= '0;
        char_ch.last_in_message <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_all_kinds();
        test_flags_and_aborts();
        test_dropped_kinds();
        test_backpressure();
        test_long_message();
        test_random(125, 1'b1, 1'b1);
        test_random(125, 1'b0, 1'b1);
        test_random(125, 1'b1, 1'b0);
        test_random(125, 1'b0, 1'b0);
        wait_idle();

        mismatches += pending_scans.size();
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/fss_pkg.sv
src/fss_char_if.sv
src/fss_res_if.sv
src/fss_step.sv
src/format_specifier_scanner_unit.sv
test/testbench.sv
